FILE: rtl/pci_pkg.sv
// shared constants, lane indices and pipeline control record for the pillar interpolator
`default_nettype none

package pci_pkg;

  // default coordinate width (signed fixed point)
  localparam int unsigned COORD_WIDTH_DEF = 40;

  // vertical threshold register
  localparam int unsigned THR_W = 20;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(655);

  // four products per item: two depths times two coordinates
  localparam int unsigned LANES   = 4;
  localparam int unsigned LANE_UX = 0;
  localparam int unsigned LANE_UY = 1;
  localparam int unsigned LANE_LX = 2;
  localparam int unsigned LANE_LY = 3;

  // register stages inside the split multiplier
  localparam int unsigned MUL_STAGES = 3;

  // control that travels beside the datapath
  typedef struct packed {
    logic             valid;
    logic             vertical;
    logic [LANES-1:0] neg;
  } pci_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/pillar_corner_interpolator_core.sv
// top level: corner-point pillar interpolator, front, multipliers, divider, output
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+------------------------------------------
//  in_      | in  | in_valid / in_stall  | top/bottom x,y,z, upper/lower corner depth
//  out_     | out | out_valid / out_stall| upper/lower x,y, is_vertical
//  cfg_     | in  | cfg_wr_en            | cfg_wr_data: vertical threshold
//
//  one item per cycle unless in_stall is up; the divider resolves one quotient bit
//  per pipeline stage
//  reset is synchronous, active low: clears all valid bits, threshold returns to 655
//  out_stall holds the output register; the next result parks in a skid slot, and
//  only then the whole pipeline freezes and in_stall rises (in_stall is registered)
//  the fraction position cancels in the ratio, so no fraction-width setting exists
`default_nettype none

module pillar_corner_interpolator_core
  import pci_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          cfg_wr_en,
  input  logic [THR_W-1:0]              cfg_wr_data,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_top_x,
  input  logic signed [COORD_WIDTH-1:0] in_top_y,
  input  logic signed [COORD_WIDTH-1:0] in_top_z,
  input  logic signed [COORD_WIDTH-1:0] in_bottom_x,
  input  logic signed [COORD_WIDTH-1:0] in_bottom_y,
  input  logic signed [COORD_WIDTH-1:0] in_bottom_z,
  input  logic signed [COORD_WIDTH-1:0] in_upper_corner_depth,
  input  logic signed [COORD_WIDTH-1:0] in_lower_corner_depth,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_upper_x,
  output logic signed [COORD_WIDTH-1:0] out_upper_y,
  output logic signed [COORD_WIDTH-1:0] out_lower_x,
  output logic signed [COORD_WIDTH-1:0] out_lower_y,
  output logic                          out_is_vertical
);

  localparam int unsigned W      = COORD_WIDTH;
  localparam int unsigned MAG_W  = W + 1;
  localparam int unsigned PW     = 2 * MAG_W;
  localparam int unsigned SIDE_W = $bits(pci_ctl_t) + 2 * W;
  localparam int unsigned SIDE_D = MUL_STAGES + W + 1;

  logic [THR_W-1:0]          thr_r;
  logic                      pipe_en;
  logic                      hold;

  logic [MAG_W-1:0]          mag_dz, mag_u, mag_l, mag_x, mag_y;
  logic [W-1:0]              top_x_f, top_y_f;
  pci_ctl_t                  ctl_f;

  logic [LANES-1:0][PW-1:0]  prod;
  logic [MAG_W-1:0]          den_d;
  logic [LANES-1:0][MAG_W-1:0] quot;

  logic [SIDE_W-1:0]         side_in, side_out;
  pci_ctl_t                  ctl_d;
  logic [W-1:0]              top_x_d, top_y_d;

  logic [LANES-1:0][W-1:0]   res;
  logic                      vert;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // whole pipeline advances unless the skid slot is occupied
  assign pipe_en  = !hold;
  assign in_stall = hold;

  pci_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (pipe_en),
    .in_valid    (in_valid),
    .thr         (thr_r),
    .top_x       (in_top_x),
    .top_y       (in_top_y),
    .top_z       (in_top_z),
    .bottom_x    (in_bottom_x),
    .bottom_y    (in_bottom_y),
    .bottom_z    (in_bottom_z),
    .upper_depth (in_upper_corner_depth),
    .lower_depth (in_lower_corner_depth),
    .mag_dz      (mag_dz),
    .mag_u       (mag_u),
    .mag_l       (mag_l),
    .mag_x       (mag_x),
    .mag_y       (mag_y),
    .top_x_q     (top_x_f),
    .top_y_q     (top_y_f),
    .ctl         (ctl_f)
  );

  // depth offset times coordinate span, one multiplier per corner coordinate
  pci_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul_ux (
    .clk (clk), .en (pipe_en), .a (mag_u), .b (mag_x), .prod (prod[LANE_UX])
  );

  pci_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul_uy (
    .clk (clk), .en (pipe_en), .a (mag_u), .b (mag_y), .prod (prod[LANE_UY])
  );

  pci_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul_lx (
    .clk (clk), .en (pipe_en), .a (mag_l), .b (mag_x), .prod (prod[LANE_LX])
  );

  pci_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul_ly (
    .clk (clk), .en (pipe_en), .a (mag_l), .b (mag_y), .prod (prod[LANE_LY])
  );

  // divisor waits out the multiplier stages
  pci_delay #(.WIDTH(MAG_W), .DEPTH(MUL_STAGES)) u_den_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (pipe_en),
    .d     (mag_dz),
    .q     (den_d)
  );

  pci_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
    .clk  (clk),
    .en   (pipe_en),
    .num  (prod),
    .den  (den_d),
    .quot (quot)
  );

  // control and top coordinates ride alongside multiply and divide
  assign side_in = {ctl_f, top_x_f, top_y_f};
  assign {ctl_d, top_x_d, top_y_d} = side_out;

  pci_delay #(.WIDTH(SIDE_W), .DEPTH(SIDE_D)) u_side_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (pipe_en),
    .d     (side_in),
    .q     (side_out)
  );

  pci_out #(.COORD_WIDTH(COORD_WIDTH)) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .quot      (quot),
    .top_x     (top_x_d),
    .top_y     (top_y_d),
    .ctl       (ctl_d),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .hold      (hold),
    .res       (res),
    .vert      (vert)
  );

  assign out_upper_x     = res[LANE_UX];
  assign out_upper_y     = res[LANE_UY];
  assign out_lower_x     = res[LANE_LX];
  assign out_lower_y     = res[LANE_LY];
  assign out_is_vertical = vert;

endmodule

`default_nettype wire

FILE: rtl/pci_delay.sv
// enabled shift line that keeps side data aligned with the datapath stages
`default_nettype none

module pci_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] line_r [DEPTH];

  // shift on every pipeline advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        line_r[i] <= '0;
      end
    end else if (en) begin
      line_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        line_r[i] <= line_r[i-1];
      end
    end
  end

  assign q = line_r[DEPTH-1];

endmodule

`default_nettype wire

FILE: rtl/pci_front.sv
// front stages: pillar differences, magnitudes, signs and vertical test
`default_nettype none

module pci_front
  import pci_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [THR_W-1:0]              thr,
  input  logic signed [COORD_WIDTH-1:0] top_x,
  input  logic signed [COORD_WIDTH-1:0] top_y,
  input  logic signed [COORD_WIDTH-1:0] top_z,
  input  logic signed [COORD_WIDTH-1:0] bottom_x,
  input  logic signed [COORD_WIDTH-1:0] bottom_y,
  input  logic signed [COORD_WIDTH-1:0] bottom_z,
  input  logic signed [COORD_WIDTH-1:0] upper_depth,
  input  logic signed [COORD_WIDTH-1:0] lower_depth,
  output logic [COORD_WIDTH:0]          mag_dz,
  output logic [COORD_WIDTH:0]          mag_u,
  output logic [COORD_WIDTH:0]          mag_l,
  output logic [COORD_WIDTH:0]          mag_x,
  output logic [COORD_WIDTH:0]          mag_y,
  output logic [COORD_WIDTH-1:0]        top_x_q,
  output logic [COORD_WIDTH-1:0]        top_y_q,
  output pci_ctl_t                      ctl
);

  localparam int unsigned W     = COORD_WIDTH;
  localparam int unsigned PAD_W = W + 1 - THR_W;

  // stage one: signed differences, one bit wider than the coordinates
  logic [W:0]   dz_r, du_r, dl_r, dx_r, dy_r;
  logic [W-1:0] tx1_r, ty1_r;
  logic         v1_r;

  // stage two: magnitudes and signs
  logic [W:0]   mdz_r, mu_r, ml_r, mx_r, my_r;
  logic [W-1:0] tx2_r, ty2_r;
  pci_ctl_t     ctl_r;

  logic [W:0]   mdz_nxt;
  pci_ctl_t     ctl_nxt;

  function automatic logic [W:0] mag_of(input logic [W:0] d);
    mag_of = d[W] ? (~d + 1'b1) : d;
  endfunction

  // differences, valid tracked separately
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dz_r  <= {bottom_z[W-1], bottom_z} - {top_z[W-1], top_z};
      du_r  <= {upper_depth[W-1], upper_depth} - {top_z[W-1], top_z};
      dl_r  <= {lower_depth[W-1], lower_depth} - {top_z[W-1], top_z};
      dx_r  <= {top_x[W-1], top_x} - {bottom_x[W-1], bottom_x};
      dy_r  <= {top_y[W-1], top_y} - {bottom_y[W-1], bottom_y};
      tx1_r <= top_x;
      ty1_r <= top_y;
    end
  end

  // vertical test and combined quotient signs
  always_comb begin
    mdz_nxt          = mag_of(dz_r);
    ctl_nxt.valid    = v1_r;
    ctl_nxt.vertical = (mdz_nxt <= {{PAD_W{1'b0}}, thr});
    ctl_nxt.neg[LANE_UX] = du_r[W] ^ dx_r[W] ^ dz_r[W];
    ctl_nxt.neg[LANE_UY] = du_r[W] ^ dy_r[W] ^ dz_r[W];
    ctl_nxt.neg[LANE_LX] = dl_r[W] ^ dx_r[W] ^ dz_r[W];
    ctl_nxt.neg[LANE_LY] = dl_r[W] ^ dy_r[W] ^ dz_r[W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mdz_r <= mdz_nxt;
      mu_r  <= mag_of(du_r);
      ml_r  <= mag_of(dl_r);
      mx_r  <= mag_of(dx_r);
      my_r  <= mag_of(dy_r);
      tx2_r <= tx1_r;
      ty2_r <= ty1_r;
    end
  end

  assign mag_dz  = mdz_r;
  assign mag_u   = mu_r;
  assign mag_l   = ml_r;
  assign mag_x   = mx_r;
  assign mag_y   = my_r;
  assign top_x_q = tx2_r;
  assign top_y_q = ty2_r;
  assign ctl     = ctl_r;

endmodule

`default_nettype wire

FILE: rtl/pci_mul.sv
// unsigned magnitude multiplier split into half-width partial products, three stages
`default_nettype none

module pci_mul
  import pci_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [COORD_WIDTH:0]       a,
  input  logic [COORD_WIDTH:0]       b,
  output logic [2*COORD_WIDTH+1:0]   prod
);

  localparam int unsigned MAG_W = COORD_WIDTH + 1;
  localparam int unsigned LO_W  = (MAG_W + 1) / 2;
  localparam int unsigned HI_W  = MAG_W - LO_W;
  localparam int unsigned PW    = 2 * MAG_W;

  logic [LO_W-1:0]   a_lo, b_lo;
  logic [HI_W-1:0]   a_hi, b_hi;

  logic [2*LO_W-1:0] p00_r;
  logic [MAG_W-1:0]  p01_r, p10_r;
  logic [2*HI_W-1:0] p11_r;
  logic [MAG_W:0]    mid_r;
  logic [PW-1:0]     cat_r;
  logic [PW-1:0]     prod_r;

  assign a_lo = a[LO_W-1:0];
  assign a_hi = a[MAG_W-1:LO_W];
  assign b_lo = b[LO_W-1:0];
  assign b_hi = b[MAG_W-1:LO_W];

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      p00_r <= (2*LO_W)'(a_lo) * (2*LO_W)'(b_lo);
      p01_r <= MAG_W'(a_lo) * MAG_W'(b_hi);
      p10_r <= MAG_W'(a_hi) * MAG_W'(b_lo);
      p11_r <= (2*HI_W)'(a_hi) * (2*HI_W)'(b_hi);
    end
  end

  // cross terms summed, outer terms do not overlap
  always_ff @(posedge clk) begin
    if (en) begin
      mid_r <= (MAG_W+1)'(p01_r) + (MAG_W+1)'(p10_r);
      cat_r <= {p11_r, p00_r};
    end
  end

  // final product
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= cat_r + (PW'(mid_r) << LO_W);
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

FILE: rtl/pci_div.sv
// four-lane restoring divider, one quotient bit per stage, shared divisor line
`default_nettype none

module pci_div
  import pci_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [LANES-1:0][2*COORD_WIDTH+1:0]  num,
  input  logic [COORD_WIDTH:0]                 den,
  output logic [LANES-1:0][COORD_WIDTH:0]      quot
);

  localparam int unsigned W     = COORD_WIDTH;
  localparam int unsigned MAG_W = W + 1;
  localparam int unsigned PW    = 2 * MAG_W;
  localparam int unsigned STEPS = W;

  // partial remainder, low numerator bits shifting out as quotient bits shift in
  logic [MAG_W-1:0] rem_r [STEPS][LANES];
  logic [W-1:0]     acc_r [STEPS+1][LANES];
  logic [LANES-1:0] ovf_r [STEPS+1];
  logic [MAG_W-1:0] den_r [STEPS];

  // entry stage: a quotient of 2^W or more only ever saturates, so flag it
  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= den;
      for (int l = 0; l < LANES; l++) begin
        ovf_r[0][l] <= (num[l][PW-1:W] >= (W+2)'(den));
        rem_r[0][l] <= num[l][PW-2:W];
        acc_r[0][l] <= num[l][W-1:0];
      end
    end
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    logic [MAG_W:0]   part [LANES];
    logic [MAG_W:0]   less [LANES];
    logic [LANES-1:0] ge;

    // shift in the next numerator bit and trial-subtract
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        part[l] = {rem_r[k-1][l], acc_r[k-1][l][W-1]};
        less[l] = part[l] - {1'b0, den_r[k-1]};
        ge[l]   = (part[l] >= {1'b0, den_r[k-1]});
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ovf_r[k] <= ovf_r[k-1];
        for (int l = 0; l < LANES; l++) begin
          acc_r[k][l] <= {acc_r[k-1][l][W-2:0], ge[l]};
        end
      end
    end

    // the last step needs no remainder or divisor after it
    if (k < STEPS) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          den_r[k] <= den_r[k-1];
          for (int l = 0; l < LANES; l++) begin
            rem_r[k][l] <= ge[l] ? less[l][MAG_W-1:0] : part[l][MAG_W-1:0];
          end
        end
      end
    end
  end

  // clamp flagged quotients at 2^W
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quot[l] = ovf_r[STEPS][l] ? {1'b1, {W{1'b0}}} : {1'b0, acc_r[STEPS][l]};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pci_out.sv
// final subtract and saturation, output register with one skid slot
`default_nettype none

module pci_out
  import pci_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [LANES-1:0][COORD_WIDTH:0]   quot,
  input  logic [COORD_WIDTH-1:0]            top_x,
  input  logic [COORD_WIDTH-1:0]            top_y,
  input  pci_ctl_t                          ctl,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic                              hold,
  output logic [LANES-1:0][COORD_WIDTH-1:0] res,
  output logic                              vert
);

  localparam int unsigned W = COORD_WIDTH;
  localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};

  logic [LANES-1:0][W-1:0] lane_top;
  logic [W+1:0]            sum [LANES];
  logic [LANES-1:0][W-1:0] res_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    skid_valid_r, skid_valid_nxt;
  logic [LANES-1:0][W-1:0] out_res_r, skid_res_r;
  logic                    out_vert_r, skid_vert_r;
  logic                    out_take, out_free;
  logic                    load_from_skid, load_from_pipe, load_skid;

  // top coordinate for each lane
  always_comb begin
    lane_top[LANE_UX] = top_x;
    lane_top[LANE_LX] = top_x;
    lane_top[LANE_UY] = top_y;
    lane_top[LANE_LY] = top_y;
  end

  // top minus signed quotient, then clamp to the coordinate range; vertical pillars pass top
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (ctl.neg[l]) begin
        sum[l] = {{2{lane_top[l][W-1]}}, lane_top[l]} + {1'b0, quot[l]};
      end else begin
        sum[l] = {{2{lane_top[l][W-1]}}, lane_top[l]} - {1'b0, quot[l]};
      end
      if (ctl.vertical) begin
        res_nxt[l] = lane_top[l];
      end else if (sum[l][W+1:W-1] == 3'b000 || sum[l][W+1:W-1] == 3'b111) begin
        res_nxt[l] = sum[l][W-1:0];
      end else if (sum[l][W+1]) begin
        res_nxt[l] = SAT_MIN;
      end else begin
        res_nxt[l] = SAT_MAX;
      end
    end
  end

  // output register and skid slot control
  assign out_take = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || out_take;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    load_from_skid = 1'b0;
    load_from_pipe = 1'b0;
    load_skid      = 1'b0;
    priority if (skid_valid_r) begin
      if (out_free) begin
        load_from_skid = 1'b1;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (out_free) begin
      load_from_pipe = ctl.valid;
      out_valid_nxt  = ctl.valid;
    end else begin
      // output held: an arriving result parks in the skid slot
      load_skid      = ctl.valid;
      skid_valid_nxt = ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_from_skid) begin
      out_res_r  <= skid_res_r;
      out_vert_r <= skid_vert_r;
    end else if (load_from_pipe) begin
      out_res_r  <= res_nxt;
      out_vert_r <= ctl.vertical;
    end
    if (load_skid) begin
      skid_res_r  <= res_nxt;
      skid_vert_r <= ctl.vertical;
    end
  end

  assign out_valid = out_valid_r;
  assign hold      = skid_valid_r;
  assign res       = out_res_r;
  assign vert      = out_vert_r;

  // skid slot only ever fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot full with empty output register");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid slot filled without a stalled output");

  // a vertical pillar gives both corners the same x,y
  a_vertical_same: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_vert_r) |->
      (out_res_r[LANE_UX] == out_res_r[LANE_LX]) &&
      (out_res_r[LANE_UY] == out_res_r[LANE_LY]))
    else $error("vertical result with differing corners");

endmodule

`default_nettype wire

FILE: verif/pillar_corner_interpolator_core_tb.sv
// self-checking testbench for the pillar corner interpolator core
`timescale 1ns / 100ps

module testbench
  import pci_pkg::*;
();

  localparam int CW = COORD_WIDTH_DEF;
  localparam int LATENCY = CW + 7;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 200;
  localparam int NUM_PHASES = 5;
  localparam int ITEMS_PER_PHASE = 306;
  localparam int QUIET_ITEMS = 50;
  localparam int PRESSURE_PHASE = 3;
  localparam int PRESSURE_ITEMS = 150;
  localparam int NUM_DIRECTED = 16;
  localparam int MAX_REPORTS = 10;

  localparam logic [CW-1:0] FIELD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] FIELD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [127:0] COORD_MAX = (128'sd1 <<< (CW-1)) - 128'sd1;
  localparam logic signed [127:0] COORD_MIN = -(128'sd1 <<< (CW-1));

  typedef struct packed {
    logic [CW-1:0] top_x, top_y, top_z;
    logic [CW-1:0] bottom_x, bottom_y, bottom_z;
    logic [CW-1:0] upper_depth, lower_depth;
  } pillar_t;

  typedef struct packed {
    logic [CW-1:0] upper_x, upper_y, lower_x, lower_y;
    logic          vertical;
  } corner_t;

  typedef struct packed {
    pillar_t p;
    logic    known;
    corner_t want;
  } dir_row_t;

  typedef enum {
    GEO_REALISTIC, GEO_NEAR_LIMIT, GEO_VERTICAL, GEO_WILD, GEO_SATURATE
  } pillar_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             cfg_wr_en = 1'b0;
  logic [THR_W-1:0] cfg_wr_data = '0;

  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [CW-1:0] in_top_x = '0;
  logic [CW-1:0] in_top_y = '0;
  logic [CW-1:0] in_top_z = '0;
  logic [CW-1:0] in_bottom_x = '0;
  logic [CW-1:0] in_bottom_y = '0;
  logic [CW-1:0] in_bottom_z = '0;
  logic [CW-1:0] in_upper_corner_depth = '0;
  logic [CW-1:0] in_lower_corner_depth = '0;

  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [CW-1:0] out_upper_x;
  logic [CW-1:0] out_upper_y;
  logic [CW-1:0] out_lower_x;
  logic [CW-1:0] out_lower_y;
  logic          out_is_vertical;

  // threshold as the block should hold it, and pending corner results
  logic [THR_W-1:0] thr_shadow = THR_RESET;
  corner_t          corner_q [$];

  dir_row_t         directed_tbl [NUM_DIRECTED];
  logic [THR_W-1:0] phase_thr [NUM_PHASES];

  logic quiet = 1'b0;
  logic long_hold_req = 1'b0;

  int items_sent = 0;
  int results_checked = 0;
  int vertical_seen = 0;
  int inverted_seen = 0;
  int saturated_seen = 0;
  int mismatch_count = 0;
  int unexpected_count = 0;
  int blocked_cycles = 0;
  int idle_run = 0;

  pillar_corner_interpolator_core #(
    .COORD_WIDTH(CW)
  ) dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_top_x              (in_top_x),
    .in_top_y              (in_top_y),
    .in_top_z              (in_top_z),
    .in_bottom_x           (in_bottom_x),
    .in_bottom_y           (in_bottom_y),
    .in_bottom_z           (in_bottom_z),
    .in_upper_corner_depth (in_upper_corner_depth),
    .in_lower_corner_depth (in_lower_corner_depth),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_upper_x           (out_upper_x),
    .out_upper_y           (out_upper_y),
    .out_lower_x           (out_lower_x),
    .out_lower_y           (out_lower_y),
    .out_is_vertical       (out_is_vertical)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one axis: top - (depth - ztop) * (top - bot) / dz, truncated, then clamped
  function automatic logic [CW-1:0] lerp_axis(logic [CW-1:0] top, bot, depth, ztop,
                                               logic [127:0] dz_mag, logic dz_neg);
    logic signed [127:0] t, along, span, r;
    logic [127:0] along_mag, span_mag, q;
    t = $signed(top);
    along = $signed(depth) - $signed(ztop);
    span = t - $signed(bot);
    along_mag = along[127] ? -along : along;
    span_mag = span[127] ? -span : span;
    q = (along_mag * span_mag) / dz_mag;
    if (along[127] ^ span[127] ^ dz_neg) q = -q;
    r = t - $signed(q);
    if (r > COORD_MAX) r = COORD_MAX;
    else if (r < COORD_MIN) r = COORD_MIN;
    return r[CW-1:0];
  endfunction

  // both corners of one pillar under the given vertical threshold
  function automatic corner_t interpolate_corners(pillar_t p, logic [THR_W-1:0] thr);
    logic signed [127:0] dz;
    logic [127:0] dz_mag;
    corner_t c;
    dz = $signed(p.bottom_z) - $signed(p.top_z);
    dz_mag = dz[127] ? -dz : dz;
    if (dz_mag <= {{(128-THR_W){1'b0}}, thr}) begin
      c.upper_x = p.top_x;
      c.upper_y = p.top_y;
      c.lower_x = p.top_x;
      c.lower_y = p.top_y;
      c.vertical = 1'b1;
    end else begin
      c.upper_x = lerp_axis(p.top_x, p.bottom_x, p.upper_depth, p.top_z, dz_mag, dz[127]);
      c.upper_y = lerp_axis(p.top_y, p.bottom_y, p.upper_depth, p.top_z, dz_mag, dz[127]);
      c.lower_x = lerp_axis(p.top_x, p.bottom_x, p.lower_depth, p.top_z, dz_mag, dz[127]);
      c.lower_y = lerp_axis(p.top_y, p.bottom_y, p.lower_depth, p.top_z, dz_mag, dz[127]);
      c.vertical = 1'b0;
    end
    return c;
  endfunction

  function automatic dir_row_t make_row(logic [CW-1:0] tx, ty, tz, bx, by, bz, du, dl,
                                        logic known,
                                        logic [CW-1:0] ux, uy, lx, ly, logic vert);
    dir_row_t row;
    row.p = '{top_x: tx, top_y: ty, top_z: tz, bottom_x: bx, bottom_y: by,
              bottom_z: bz, upper_depth: du, lower_depth: dl};
    row.known = known;
    row.want = '{upper_x: ux, upper_y: uy, lower_x: lx, lower_y: ly, vertical: vert};
    return row;
  endfunction

  // signed random value spanning the given number of bits
  function automatic longint coord(int bits);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return $signed(raw) >>> (64 - bits);
  endfunction

  function automatic logic [CW-1:0] to_field(longint v);
    return v[CW-1:0];
  endfunction

  // mostly well-formed pillars, plus threshold edges, wild values and overflow stress
  function automatic pillar_t random_pillar(logic [THR_W-1:0] thr);
    pillar_t p;
    pillar_kind_t kind;
    int unsigned roll;
    longint tz, dz, dir;
    roll = $urandom_range(0, 99);
    if (roll < 50) kind = GEO_REALISTIC;
    else if (roll < 65) kind = GEO_NEAR_LIMIT;
    else if (roll < 75) kind = GEO_VERTICAL;
    else if (roll < 90) kind = GEO_WILD;
    else kind = GEO_SATURATE;
    dir = ($urandom_range(0, 1) == 0) ? 64'sd1 : -64'sd1;
    p.top_x = to_field(coord(CW));
    p.top_y = to_field(coord(CW));
    p.top_z = to_field(coord(CW));
    p.bottom_x = to_field(coord(CW));
    p.bottom_y = to_field(coord(CW));
    p.bottom_z = to_field(coord(CW));
    p.upper_depth = to_field(coord(CW));
    p.lower_depth = to_field(coord(CW));
    tz = coord(38);
    case (kind)
      GEO_REALISTIC: begin
        // inverted pillars are the exception here
        dir = ($urandom_range(0, 7) == 0) ? -64'sd1 : 64'sd1;
        dz = longint'(thr) + 1 + longint'($urandom_range(0, 1 << 26));
        p.top_x = to_field(coord(34));
        p.top_y = to_field(coord(34));
        p.bottom_x = to_field(longint'($signed(p.top_x)) + coord(28));
        p.bottom_y = to_field(longint'($signed(p.top_y)) + coord(28));
        p.top_z = to_field(tz);
        p.bottom_z = to_field(tz + dir * dz);
        p.upper_depth = to_field(tz + dir * longint'($urandom_range(0, 32'(dz))));
        p.lower_depth = to_field(tz + dir * longint'($urandom_range(0, 32'(dz))) + coord(20));
      end
      GEO_NEAR_LIMIT: begin
        dz = longint'(thr) + longint'($urandom_range(0, 2)) - 1;
        p.top_z = to_field(tz);
        p.bottom_z = to_field(tz + dir * dz);
      end
      GEO_VERTICAL: begin
        dz = longint'($urandom_range(0, 32'(thr)));
        p.top_z = to_field(tz);
        p.bottom_z = to_field(tz + dir * dz);
      end
      GEO_SATURATE: begin
        dz = longint'(thr) + 1 + longint'($urandom_range(0, 3));
        p.top_z = to_field(tz);
        p.bottom_z = to_field(tz + dir * dz);
      end
      default: ;
    endcase
    return p;
  endfunction

  // idle length for either side: mostly short, now and then long
  function automatic int pick_gap();
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one pillar and record its corners once the transfer happens
  task automatic send_pillar(input pillar_t p, input logic known, input corner_t typed);
    int gap;
    corner_t want;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_top_x <= p.top_x;
    in_top_y <= p.top_y;
    in_top_z <= p.top_z;
    in_bottom_x <= p.bottom_x;
    in_bottom_y <= p.bottom_y;
    in_bottom_z <= p.bottom_z;
    in_upper_corner_depth <= p.upper_depth;
    in_lower_corner_depth <= p.lower_depth;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = known ? typed : interpolate_corners(p, thr_shadow);
    corner_q.push_back(want);
    items_sent++;
    if (want.vertical) vertical_seen++;
    else begin
      if ($signed(p.bottom_z) < $signed(p.top_z)) inverted_seen++;
      if (want.upper_x inside {FIELD_MAX, FIELD_MIN} || want.upper_y inside {FIELD_MAX, FIELD_MIN}
          || want.lower_x inside {FIELD_MAX, FIELD_MIN}
          || want.lower_y inside {FIELD_MAX, FIELD_MIN})
        saturated_seen++;
    end
  endtask

  // threshold write, only once every pending result has been transferred
  task automatic set_threshold(input logic [THR_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (corner_q.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    thr_shadow = value;
  endtask

  // compare one result transfer with the oldest pending corners
  task automatic check_result();
    corner_t got, want;
    got.upper_x = out_upper_x;
    got.upper_y = out_upper_y;
    got.lower_x = out_lower_x;
    got.lower_y = out_lower_y;
    got.vertical = out_is_vertical;
    if (corner_q.size() == 0) begin
      unexpected_count++;
      if (mismatch_count + unexpected_count <= MAX_REPORTS)
        $display("%0t: result with nothing pending: upper (%0d,%0d) lower (%0d,%0d)",
                 $realtime, $signed(got.upper_x), $signed(got.upper_y),
                 $signed(got.lower_x), $signed(got.lower_y));
    end else begin
      want = corner_q.pop_front();
      results_checked++;
      if (got.upper_x !== want.upper_x || got.upper_y !== want.upper_y ||
          got.lower_x !== want.lower_x || got.lower_y !== want.lower_y ||
          got.vertical !== want.vertical) begin
        mismatch_count++;
        if (mismatch_count + unexpected_count <= MAX_REPORTS) begin
          $display("%0t: result %0d got  upper (%0d,%0d) lower (%0d,%0d) vertical %0b",
                   $realtime, results_checked, $signed(got.upper_x), $signed(got.upper_y),
                   $signed(got.lower_x), $signed(got.lower_y), got.vertical);
          $display("%0t: result %0d want upper (%0d,%0d) lower (%0d,%0d) vertical %0b",
                   $realtime, results_checked, $signed(want.upper_x), $signed(want.upper_y),
                   $signed(want.lower_x), $signed(want.lower_y), want.vertical);
        end
      end
    end
  endtask

  // result side
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
  end

  // receiver stall pattern, with one long hold when asked
  initial begin : receiver
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else begin
        burst = pick_gap();
        out_stall <= (burst > 0);
        if (burst > 0) burst--;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (in_valid && in_stall) blocked_cycles <= blocked_cycles + 1;
    if (idle_run >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending",
               idle_run, corner_q.size());
      $display("FAIL pillar_corner_interpolator_core");
      $finish;
    end
  end

  initial begin : stimulus
    // zero pillar, threshold edges both ways, inverted, overflow, truncation, bit patterns
    directed_tbl[0] = make_row('0, '0, '0, '0, '0, '0, '0, '0,
                               1'b1, '0, '0, '0, '0, 1'b1);
    directed_tbl[1] = make_row(FIELD_MAX, FIELD_MIN, '0, '0, '0, 40'sd655, '0, '0,
                               1'b1, FIELD_MAX, FIELD_MIN, FIELD_MAX, FIELD_MIN, 1'b1);
    directed_tbl[2] = make_row('0, '0, '0, 40'sd656, -40'sd656, 40'sd656, '0, 40'sd656,
                               1'b1, '0, '0, 40'sd656, -40'sd656, 1'b0);
    directed_tbl[3] = make_row('0, '0, 40'sd656, 40'sd1000, 40'sd2000, '0, 40'sd656, '0,
                               1'b1, '0, '0, 40'sd1000, 40'sd2000, 1'b0);
    directed_tbl[4] = make_row(FIELD_MAX, '0, '0, FIELD_MIN, '0, 40'sd1048576,
                               -40'sd1048576, '0,
                               1'b1, FIELD_MAX, '0, FIELD_MAX, '0, 1'b0);
    directed_tbl[5] = make_row(FIELD_MIN, '0, '0, FIELD_MAX, '0, 40'sd1048576,
                               -40'sd1048576, '0,
                               1'b1, FIELD_MIN, '0, FIELD_MIN, '0, 1'b0);
    directed_tbl[6] = make_row('0, '0, '0, 40'sd1, -40'sd1, 40'sd1000, 40'sd999, 40'sd1001,
                               1'b1, '0, '0, 40'sd1, -40'sd1, 1'b0);
    directed_tbl[7] = make_row(40'sd12345, -40'sd6789, 40'sd655, FIELD_MIN, FIELD_MAX, '0,
                               FIELD_MAX, FIELD_MIN,
                               1'b1, 40'sd12345, -40'sd6789, 40'sd12345, -40'sd6789, 1'b1);
    directed_tbl[8] = make_row(-40'sd5000, 40'sd7000, 40'sd656, 40'sd3000, -40'sd3000, '0,
                               40'sd100000, -40'sd100000, 1'b0, '0, '0, '0, '0, 1'b0);
    directed_tbl[9] = make_row(FIELD_MAX, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MAX,
                               FIELD_MAX, FIELD_MAX, FIELD_MIN, 1'b0, '0, '0, '0, '0, 1'b0);
    directed_tbl[10] = make_row('1, '1, '1, '1, '1, '1, '1, '1,
                                1'b1, '1, '1, '1, '1, 1'b1);
    directed_tbl[11] = make_row(40'h55_5555_5555, 40'hAA_AAAA_AAAA, 40'h00_0001_0000,
                                40'hAA_AAAA_AAAA, 40'h55_5555_5555, 40'h00_0100_0000,
                                40'h55_5555_5555, 40'hAA_AAAA_AAAA,
                                1'b0, '0, '0, '0, '0, 1'b0);
    directed_tbl[12] = make_row(40'hAA_AAAA_AAAA, 40'h55_5555_5555, 40'h55_5555_5555,
                                40'h55_5555_5555, 40'hAA_AAAA_AAAA, 40'hAA_AAAA_AAAA,
                                40'hAA_AAAA_AAAA, 40'h55_5555_5555,
                                1'b0, '0, '0, '0, '0, 1'b0);
    // 100.0 / 200.0 / 1000.0 down to 110.0 / 190.0 / 1100.0, corners inside the pillar
    directed_tbl[13] = make_row(40'sd6553600, 40'sd13107200, 40'sd65536000,
                                40'sd7208960, 40'sd12451840, 40'sd72089600,
                                40'sd67174400, 40'sd68812800, 1'b0, '0, '0, '0, '0, 1'b0);
    // same pillar, corners beyond both ends
    directed_tbl[14] = make_row(40'sd6553600, 40'sd13107200, 40'sd65536000,
                                40'sd7208960, 40'sd12451840, 40'sd72089600,
                                40'sd58982400, 40'sd78643200, 1'b0, '0, '0, '0, '0, 1'b0);
    directed_tbl[15] = make_row(40'sd1, -40'sd1, FIELD_MIN, FIELD_MIN, FIELD_MAX,
                                40'h80_0010_0000, FIELD_MIN, FIELD_MAX,
                                1'b0, '0, '0, '0, '0, 1'b0);

    phase_thr[0] = THR_RESET;
    phase_thr[1] = '0;
    phase_thr[2] = '1;
    phase_thr[3] = THR_W'($urandom);
    phase_thr[4] = THR_W'(1);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_pillar(directed_tbl[i].p, directed_tbl[i].known, directed_tbl[i].want);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) set_threshold(phase_thr[ph]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // back-to-back stretch at the start of each phase; one carries the long output hold
        quiet = (n < QUIET_ITEMS) || (ph == PRESSURE_PHASE && n < PRESSURE_ITEMS);
        if (ph == PRESSURE_PHASE && n == 0) long_hold_req = 1'b1;
        send_pillar(random_pillar(thr_shadow), 1'b0, '0);
      end
      quiet = 1'b0;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (corner_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("sent %0d pillars, checked %0d results: %0d vertical, %0d inverted, %0d saturated",
             items_sent, results_checked, vertical_seen, inverted_seen, saturated_seen);
    $display("thresholds %0d, %0d, %0d, %0d, %0d; input held off %0d cycles by back-pressure",
             phase_thr[0], phase_thr[1], phase_thr[2], phase_thr[3], phase_thr[4],
             blocked_cycles);
    if (mismatch_count == 0 && unexpected_count == 0 && corner_q.size() == 0)
      $display("PASS pillar_corner_interpolator_core");
    else
      $display("FAIL pillar_corner_interpolator_core");
    $finish;
  end

endmodule
